// File: rtl/step_sequencer_gate_timer_macros.svh
// Assertion macros for the step sequencer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef STEP_SEQUENCER_GATE_TIMER_MACROS_SVH
`define STEP_SEQUENCER_GATE_TIMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSGT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSGT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ssgt_pkg.sv
// Package for the step sequencer: field widths, opcode and transport codes, item types.
// Has no dependencies; the interfaces and modules of the block import it.
`timescale 1ns / 1ps

package ssgt_pkg;

    localparam int OPCODE_W   = 3;
    localparam int STEP_IDX_W = 4;
    localparam int NOTE_W     = 7;
    localparam int PCT_W      = 7;
    localparam int STEP_LEN_W = 17;
    localparam int MODE_W     = 2;
    localparam int PROD_W     = STEP_LEN_W + PCT_W;

    localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PLAY  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_PAUSE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd4;

    localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

    localparam logic [STEP_LEN_W-1:0] STEP_LEN_RESET = 17'd6000;
    localparam logic [NOTE_W-1:0]     NOTE_RESET     = 7'd60;
    localparam logic [NOTE_W-1:0]     VELOCITY_RESET = 7'd100;
    localparam logic [PCT_W-1:0]      PCT_FULL       = 7'd100;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [STEP_IDX_W-1:0] step_index;
        logic [NOTE_W-1:0]     entry_note;
        logic [NOTE_W-1:0]     entry_velocity;
        logic [PCT_W-1:0]      entry_gate_percent;
        logic                  entry_active;
    } item_t;

    typedef struct packed {
        logic                  note_trigger;
        logic [NOTE_W-1:0]     note_number;
        logic [NOTE_W-1:0]     note_velocity;
        logic                  gate_high;
        logic [STEP_IDX_W-1:0] step_position;
        logic [MODE_W-1:0]     transport;
    } result_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] velocity;
        logic [PCT_W-1:0]  gate_percent;
        logic              active;
    } entry_t;

    typedef struct packed {
        logic                  en;
        logic [STEP_IDX_W-1:0] idx;
        entry_t                entry;
    } tbl_wr_t;

endpackage

// File: rtl/ssgt_if.sv
// Valid/ready channel interfaces for the step sequencer command and result items.
// Depends on ssgt_pkg for the field widths.
`timescale 1ns / 1ps

interface ssgt_in_if
    import ssgt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [STEP_IDX_W-1:0] step_index;
    logic [NOTE_W-1:0]     entry_note;
    logic [NOTE_W-1:0]     entry_velocity;
    logic [PCT_W-1:0]      entry_gate_percent;
    logic                  entry_active;

    modport source (
        output valid, opcode, step_index, entry_note, entry_velocity,
               entry_gate_percent, entry_active,
        input  ready
    );

    modport sink (
        input  valid, opcode, step_index, entry_note, entry_velocity,
               entry_gate_percent, entry_active,
        output ready
    );
endinterface

interface ssgt_out_if
    import ssgt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  note_trigger;
    logic [NOTE_W-1:0]     note_number;
    logic [NOTE_W-1:0]     note_velocity;
    logic                  gate_high;
    logic [STEP_IDX_W-1:0] step_position;
    logic [MODE_W-1:0]     transport;

    modport source (
        output valid, note_trigger, note_number, note_velocity, gate_high,
               step_position, transport,
        input  ready
    );

    modport sink (
        input  valid, note_trigger, note_number, note_velocity, gate_high,
               step_position, transport,
        output ready
    );
endinterface

// File: rtl/step_sequencer_gate_timer.sv
// Step sequencer with gate timer: input register, update core, step table, result register.
// Depends on ssgt_pkg, ssgt_if, ssgt_step_table and ssgt_core.
`timescale 1ns / 1ps

// The sequencer takes one command item per clock while the output is not stalled and
// returns exactly one result item for each, in order. An accepted item waits in the input
// register until the sequencer state is updated from it, and the clock edge of that update
// loads the state and the output register together, so each result passes through the input
// register and the output register. The sustained rate is one item per cycle while the
// output is not stalled; a stalled output stops the input only once both registers are full.
// The step table is held in registers whose active flags are cleared by reset, so the block
// is ready immediately after reset. The step length register is written through cfg_wr_en
// and cfg_wr_data, and should only be changed while no item is in flight.
module step_sequencer_gate_timer
    import ssgt_pkg::*;
#(
    parameter int NUM_STEPS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [STEP_LEN_W-1:0] cfg_wr_data,
    ssgt_in_if.sink               items,
    ssgt_out_if.source            results
);

    localparam int PTR_W = $clog2(NUM_STEPS);

    logic [STEP_LEN_W-1:0] step_len_reg;
    logic                  in_valid_reg;
    item_t                 in_item_reg;
    logic                  out_valid_reg;
    result_t               out_res_reg;
    logic                  advance;
    item_t                 in_item;
    tbl_wr_t               tbl_wr;
    logic [PTR_W-1:0]      tbl_rd_idx;
    entry_t                tbl_rd_entry;
    result_t               core_result;

    assign advance     = in_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_item.opcode             = items.opcode;
        in_item.step_index         = items.step_index;
        in_item.entry_note         = items.entry_note;
        in_item.entry_velocity     = items.entry_velocity;
        in_item.entry_gate_percent = items.entry_gate_percent;
        in_item.entry_active       = items.entry_active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_len_reg  <= STEP_LEN_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                step_len_reg <= cfg_wr_data;
            end
            if (items.valid && items.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_res_reg <= core_result;
        end
    end

    ssgt_step_table #(
        .NUM_STEPS (NUM_STEPS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_idx   (tbl_rd_idx),
        .rd_entry (tbl_rd_entry)
    );

    ssgt_core #(
        .NUM_STEPS (NUM_STEPS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd_en   (advance),
        .item     (in_item_reg),
        .step_len (step_len_reg),
        .rd_idx   (tbl_rd_idx),
        .rd_entry (tbl_rd_entry),
        .wr       (tbl_wr),
        .result   (core_result)
    );

    assign results.valid         = out_valid_reg;
    assign results.note_trigger  = out_res_reg.note_trigger;
    assign results.note_number   = out_res_reg.note_number;
    assign results.note_velocity = out_res_reg.note_velocity;
    assign results.gate_high     = out_res_reg.gate_high;
    assign results.step_position = out_res_reg.step_position;
    assign results.transport     = out_res_reg.transport;

endmodule

// File: rtl/ssgt_step_table.sv
// Step table: one register row per step with a write port and a combinational read.
// Depends on ssgt_pkg for the entry and write request types.
`timescale 1ns / 1ps

module ssgt_step_table
    import ssgt_pkg::*;
#(
    parameter int NUM_STEPS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tbl_wr_t                      wr,
    input  logic [$clog2(NUM_STEPS)-1:0] rd_idx,
    output entry_t                       rd_entry
);

    localparam int PTR_W  = $clog2(NUM_STEPS);
    localparam int WIDE_W = (PTR_W > STEP_IDX_W) ? PTR_W : STEP_IDX_W;

    entry_t                 data_reg [NUM_STEPS];
    logic [NUM_STEPS-1:0]   active_reg;
    logic [WIDE_W-1:0]      wr_idx_wide;
    logic                   wr_hit;

    assign wr_idx_wide = WIDE_W'(wr.idx);
    assign wr_hit      = wr.en && ({{(32 - WIDE_W){1'b0}}, wr_idx_wide} < 32'(NUM_STEPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (wr_hit)
        begin
            active_reg[wr_idx_wide[PTR_W-1:0]] <= wr.entry.active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            data_reg[wr_idx_wide[PTR_W-1:0]] <= wr.entry;
        end
    end

    // An entry never written reads as inactive, so the core ignores its other fields.
    always_comb
    begin
        rd_entry        = data_reg[rd_idx];
        rd_entry.active = active_reg[rd_idx];
    end

endmodule

// File: rtl/ssgt_core.sv
// Transport, step pointer, tick counter and gate timer state with its update logic.
// Depends on ssgt_pkg and the assertion macros in step_sequencer_gate_timer_macros.svh.
`timescale 1ns / 1ps
`include "step_sequencer_gate_timer_macros.svh"

module ssgt_core
    import ssgt_pkg::*;
#(
    parameter int NUM_STEPS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         upd_en,
    input  item_t                        item,
    input  logic [STEP_LEN_W-1:0]        step_len,
    output logic [$clog2(NUM_STEPS)-1:0] rd_idx,
    input  entry_t                       rd_entry,
    output tbl_wr_t                      wr,
    output result_t                      result
);

    localparam int PTR_W  = $clog2(NUM_STEPS);
    localparam int WIDE_W = (PTR_W > STEP_IDX_W) ? PTR_W : STEP_IDX_W;
    localparam int LIM_W  = PROD_W + 1;

    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [STEP_LEN_W-1:0] tick_reg, tick_next;
    logic                  gate_flag_reg, gate_flag_next;
    logic [STEP_LEN_W-1:0] gate_cnt_reg, gate_cnt_next;
    logic [PROD_W-1:0]     gate_prod_reg, gate_prod_next;
    logic [NOTE_W-1:0]     note_reg, note_next;
    logic [NOTE_W-1:0]     vel_reg, vel_next;

    logic [PTR_W-1:0]      ptr_wrap;
    logic [STEP_LEN_W:0]   tick_sum;
    logic [STEP_LEN_W:0]   gate_cnt_plus2;
    logic [LIM_W-1:0]      gate_limit;
    logic                  gate_close;
    logic                  enter;
    logic                  trig;
    logic [WIDE_W-1:0]     ptr_wide;

    assign ptr_wrap = (ptr_reg == PTR_W'(NUM_STEPS - 1)) ? '0 : ptr_reg + 1'b1;
    assign rd_idx   = (item.opcode == OP_TICK) ? ptr_wrap : '0;

    // The gate closes once the new count reaches floor(product / 100), which is the same as
    // the product being below 100 times one more than the new count.
    assign tick_sum       = {1'b0, tick_reg} + 1'b1;
    assign gate_cnt_plus2 = {1'b0, gate_cnt_reg} + 2'd2;
    assign gate_limit     = LIM_W'(gate_cnt_plus2) * LIM_W'(PCT_FULL);
    assign gate_close     = {1'b0, gate_prod_reg} < gate_limit;

    always_comb
    begin
        mode_next      = mode_reg;
        ptr_next       = ptr_reg;
        tick_next      = tick_reg;
        gate_flag_next = gate_flag_reg;
        gate_cnt_next  = gate_cnt_reg;
        gate_prod_next = gate_prod_reg;
        note_next      = note_reg;
        vel_next       = vel_reg;
        enter          = 1'b0;
        trig           = 1'b0;
        wr             = '0;

        unique case (item.opcode)
            OP_TICK:
            begin
                if (mode_reg == MODE_PLAYING)
                begin
                    if (gate_flag_reg)
                    begin
                        gate_cnt_next = gate_cnt_reg + 1'b1;
                        if (gate_close)
                        begin
                            gate_flag_next = 1'b0;
                        end
                    end
                    if (tick_sum >= {1'b0, step_len})
                    begin
                        tick_next = '0;
                        ptr_next  = ptr_wrap;
                        enter     = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_sum[STEP_LEN_W-1:0];
                    end
                end
            end
            OP_PLAY:
            begin
                if (mode_reg == MODE_STOPPED)
                begin
                    ptr_next  = '0;
                    tick_next = '0;
                    enter     = 1'b1;
                end
                mode_next = MODE_PLAYING;
            end
            OP_STOP:
            begin
                mode_next      = MODE_STOPPED;
                ptr_next       = '0;
                tick_next      = '0;
                gate_flag_next = 1'b0;
            end
            OP_PAUSE:
            begin
                if (mode_reg == MODE_PLAYING)
                begin
                    mode_next = MODE_PAUSED;
                end
                else if (mode_reg == MODE_PAUSED)
                begin
                    mode_next = MODE_PLAYING;
                end
            end
            OP_WRITE:
            begin
                wr.en                 = 1'b1;
                wr.idx                = item.step_index;
                wr.entry.note         = item.entry_note;
                wr.entry.velocity     = item.entry_velocity;
                wr.entry.gate_percent = (item.entry_gate_percent > PCT_FULL) ?
                                        PCT_FULL : item.entry_gate_percent;
                wr.entry.active       = item.entry_active;
            end
            default:
            begin
            end
        endcase

        if (enter && rd_entry.active)
        begin
            trig           = 1'b1;
            note_next      = rd_entry.note;
            vel_next       = rd_entry.velocity;
            gate_flag_next = 1'b1;
            gate_cnt_next  = '0;
            gate_prod_next = PROD_W'(step_len) * PROD_W'(rd_entry.gate_percent);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_STOPPED;
            ptr_reg       <= '0;
            tick_reg      <= '0;
            gate_flag_reg <= 1'b0;
            gate_cnt_reg  <= '0;
            gate_prod_reg <= '0;
            note_reg      <= NOTE_RESET;
            vel_reg       <= VELOCITY_RESET;
        end
        else if (upd_en)
        begin
            mode_reg      <= mode_next;
            ptr_reg       <= ptr_next;
            tick_reg      <= tick_next;
            gate_flag_reg <= gate_flag_next;
            gate_cnt_reg  <= gate_cnt_next;
            gate_prod_reg <= gate_prod_next;
            note_reg      <= note_next;
            vel_reg       <= vel_next;
        end
    end

    assign ptr_wide = WIDE_W'(ptr_next);

    always_comb
    begin
        result.note_trigger  = trig;
        result.note_number   = note_next;
        result.note_velocity = vel_next;
        result.gate_high     = gate_flag_next;
        result.step_position = ptr_wide[STEP_IDX_W-1:0];
        result.transport     = mode_next;
    end

    `SSGT_ASSERT_NEXT(a_trig_opens_gate, clk, rst_n, upd_en && trig,
        gate_flag_reg && (gate_cnt_reg == '0), "Triggered step did not open the gate.")
    `SSGT_ASSERT_NEXT(a_stop_rewinds, clk, rst_n, upd_en && (item.opcode == OP_STOP),
        (mode_reg == MODE_STOPPED) && (ptr_reg == '0) && !gate_flag_reg && (tick_reg == '0),
        "Stop did not rewind the transport.")
    `SSGT_ASSERT_SAME(a_ptr_in_range, clk, rst_n, 1'b1,
        {1'b0, ptr_reg} < (PTR_W + 1)'(NUM_STEPS), "Step pointer beyond the last step.")
    `SSGT_ASSERT_NEXT(a_hold_when_idle, clk, rst_n, !upd_en,
        $stable(mode_reg) && $stable(ptr_reg) && $stable(tick_reg) && $stable(gate_flag_reg),
        "Sequencer state changed without an item.")

endmodule
